/* design/crcfc_pkg.sv */
// Shared types and constants for the CRC-16 response frame checker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package crcfc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  START_BYTE_RST = 8'hAA;

  localparam logic [8:0]  LEN_SAT = 9'd511;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_CRC_ERR   = 3'd3,
    ST_DEV_ERR   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    status_e    status;
    logic [8:0] frame_length;
    logic [7:0] command_echo;
    logic [7:0] failed_command;
    logic [7:0] error_code;
  } status_item_t;

endpackage

/* design/crcfc_crc_byte.sv */
// One-byte update of the reflected CRC-16 (polynomial 0xA001), unrolled.
// Depends on crcfc_pkg.
`timescale 1ns / 1ps

module crcfc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] acc;
    acc = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ crcfc_pkg::CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

/* design/crcfc_frame.sv */
// Per-frame state (running CRC, byte count, delay line, leading bytes)
// and the end-of-frame status decision. Depends on crcfc_pkg, crcfc_crc_byte.
`timescale 1ns / 1ps

module crcfc_frame #(
  parameter int unsigned MaxFrame = crcfc_pkg::MAX_FRAME_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  crcfc_pkg::rx_item_t     item_i,
  input  logic [7:0]              start_byte_i,
  output crcfc_pkg::status_item_t result_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned CmpW = CntW + 9;

  logic [15:0]      crc_q, crc_d, crc_fed;
  logic [CntW-1:0]  count_q, count_d;
  logic [1:0][7:0]  dline_q, dline_d;
  logic [3:0][7:0]  lead_q, lead_d;
  logic             ovf_q, ovf_d;
  logic             at_max;
  logic [15:0]      sent_crc;
  logic [CmpW-1:0]  len_wide;
  crcfc_pkg::status_e status;

  crcfc_crc_byte u_crc_byte (
    .crc_i  (crc_q),
    .data_i (dline_q[0]),
    .crc_o  (crc_fed)
  );

  assign at_max = (count_q == CntW'(MaxFrame));

  always_comb begin
    crc_d   = (count_q >= CntW'(2)) ? crc_fed : crc_q;
    dline_d = {item_i.rx_byte, dline_q[1]};
    lead_d  = lead_q;
    if (count_q < CntW'(4)) begin
      lead_d[count_q[1:0]] = item_i.rx_byte;
    end
    ovf_d   = ovf_q | at_max;
    count_d = at_max ? count_q : count_q + CntW'(1);
  end

  // received CRC travels low byte first
  assign sent_crc = {dline_d[1], dline_d[0]};
  assign len_wide = {9'd0, count_d};

  always_comb begin
    if (count_d < CntW'(4)) begin
      status = crcfc_pkg::ST_SHORT;
    end else if (ovf_d) begin
      status = crcfc_pkg::ST_OVERFLOW;
    end else if (lead_d[0] != start_byte_i) begin
      status = crcfc_pkg::ST_BAD_START;
    end else if (sent_crc != crc_d) begin
      status = crcfc_pkg::ST_CRC_ERR;
    end else if (lead_d[1] == 8'h00) begin
      status = crcfc_pkg::ST_DEV_ERR;
    end else begin
      status = crcfc_pkg::ST_OK;
    end
  end

  always_comb begin
    result_o.status       = status;
    result_o.frame_length = (len_wide > CmpW'(crcfc_pkg::LEN_SAT)) ?
                            crcfc_pkg::LEN_SAT : len_wide[8:0];
    result_o.command_echo = lead_d[1];
    if (status == crcfc_pkg::ST_DEV_ERR) begin
      result_o.failed_command = lead_d[2];
      result_o.error_code     = lead_d[3];
    end else begin
      result_o.failed_command = 8'h00;
      result_o.error_code     = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= crcfc_pkg::CRC_INIT;
      count_q <= '0;
      dline_q <= '0;
      lead_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      if (item_i.frame_end) begin
        // drop all per-frame state once the status is out
        crc_q   <= crcfc_pkg::CRC_INIT;
        count_q <= '0;
        dline_q <= '0;
        lead_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        crc_q   <= crc_d;
        count_q <= count_d;
        dline_q <= dline_d;
        lead_q  <= lead_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

/* design/crc16_response_frame_checker.sv */
// Bytes are registered, then processed; a final byte's status is registered
// as it is processed. One byte per cycle, set by the input register feeding
// the one-byte CRC update; a final byte waits while a held status is stalled.
// Reset clears all frame state (CRC to 0xFFFF, count, delay line, leading
// bytes) and sets start_byte to 0xAA; no clearing pass is needed.
`timescale 1ns / 1ps

module crc16_response_frame_checker #(
  parameter int unsigned MaxFrame = crcfc_pkg::MAX_FRAME_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  crcfc_pkg::rx_item_t     in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output crcfc_pkg::status_item_t out_item_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [7:0]              cfg_data_i
);

  logic                    in_valid_q;
  crcfc_pkg::rx_item_t     in_item_q;
  logic                    out_valid_q;
  crcfc_pkg::status_item_t out_item_q;
  crcfc_pkg::status_item_t result;
  logic [7:0]              start_byte_q;
  logic                    out_free;
  logic                    advance;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  // non-final bytes never wait on the output side
  assign advance    = in_valid_q && (!in_item_q.frame_end || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= crcfc_pkg::START_BYTE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_byte_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  crcfc_frame #(
    .MaxFrame (MaxFrame)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .start_byte_i (start_byte_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_item_q.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_item_q.frame_end) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_item_q.frame_end)
    else $error("input stalled without a pending final byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(advance && in_item_q.frame_end))
    else $error("status overwritten while held");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.frame_length != 9'd0)
    else $error("status with zero frame length");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == crcfc_pkg::ST_SHORT
    |-> out_item_o.frame_length < 9'd4)
    else $error("short status on a frame of four or more bytes");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != crcfc_pkg::ST_DEV_ERR
    |-> out_item_o.failed_command == 8'h00 && out_item_o.error_code == 8'h00)
    else $error("error fields set outside a device error");

endmodule

/* verif/crc16_response_frame_checker_tb.sv */
// Self-checking testbench for crc16_response_frame_checker: directed frames, then random
// frames under four start-byte settings, checked against a CRC-16 frame predictor.
// Depends on crcfc_pkg and the crc16_response_frame_checker RTL only.
`timescale 1ns / 1ps

module crc16_response_frame_checker_tb;

  localparam int unsigned FRAME_MAX   = crcfc_pkg::MAX_FRAME_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 240;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_CRC_LO,
    SRC_CRC_HI
  } byte_src_e;

  typedef enum logic [2:0] {
    FK_GOOD,
    FK_BAD_CRC,
    FK_BAD_START,
    FK_SHORT,
    FK_NOISE,
    FK_LONG
  } frame_kind_e;

  typedef struct packed {
    byte_src_e               src;
    logic [7:0]              value;
    logic                    last;
    logic                    typed;
    crcfc_pkg::status_item_t want;
  } dir_row_t;

  localparam crcfc_pkg::status_item_t NO_WANT =
    '{crcfc_pkg::ST_OK, 9'd0, 8'h00, 8'h00, 8'h00};

  localparam int unsigned DIR_COUNT = 26;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // one-byte and two-byte short frames
    '{SRC_DATA,   8'h5A, 1'b1, 1'b1, '{crcfc_pkg::ST_SHORT, 9'd1, 8'h00, 8'h00, 8'h00}},
    '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h37, 1'b1, 1'b1, '{crcfc_pkg::ST_SHORT, 9'd2, 8'h37, 8'h00, 8'h00}},
    // wrong start byte
    '{SRC_DATA,   8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h80, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h12, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h34, 1'b1, 1'b1, '{crcfc_pkg::ST_BAD_START, 9'd4, 8'h80, 8'h00, 8'h00}},
    // four-byte error response: CRC bytes double as failed command and code
    '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, NO_WANT},
    // good frame
    '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h03, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'hFF, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, NO_WANT},
    // CRC mismatch
    '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h03, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h00, 1'b1, 1'b0, NO_WANT},
    // full error response
    '{SRC_DATA,   8'hAA, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'h01, 1'b0, 1'b0, NO_WANT},
    '{SRC_DATA,   8'hFE, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, NO_WANT}
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  crcfc_pkg::rx_item_t     in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  crcfc_pkg::status_item_t out_item_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [7:0]              cfg_data_i  = 8'h00;

  // predictor state
  logic [7:0]   start_cfg;
  logic [15:0]  crc_acc;
  int unsigned  byte_cnt;
  logic [7:0]   crc_dly [2];
  logic [7:0]   lead [4];
  bit           ovf_seen;

  crcfc_pkg::status_item_t pending_status [$];
  crcfc_pkg::status_item_t got_want;
  logic [15:0]  tx_crc;
  int unsigned  mismatches = 0;
  int unsigned  cycles     = 0;
  int unsigned  hold_left  = 0;
  bit           hold_arm   = 1'b0;
  bit           quiet      = 1'b0;

  crc16_response_frame_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ crcfc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    crc_acc    = crcfc_pkg::CRC_INIT;
    byte_cnt   = 0;
    crc_dly[0] = 8'h00;
    crc_dly[1] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      lead[k] = 8'h00;
    end
    ovf_seen = 1'b0;
  endfunction

  // Advance the frame state by one byte; return 1 with the status on the last byte.
  function automatic bit predict_status(input crcfc_pkg::rx_item_t it,
                                        output crcfc_pkg::status_item_t res);
    crcfc_pkg::status_e st;
    logic [15:0]        rx_crc;
    res = NO_WANT;
    if (byte_cnt >= 2) begin
      crc_acc = crc16_byte(crc_acc, crc_dly[0]);
    end
    crc_dly[0] = crc_dly[1];
    crc_dly[1] = it.rx_byte;
    if (byte_cnt < 4) begin
      lead[byte_cnt] = it.rx_byte;
    end
    if (byte_cnt >= FRAME_MAX) begin
      ovf_seen = 1'b1;
    end else begin
      byte_cnt++;
    end
    if (!it.frame_end) begin
      return 1'b0;
    end
    rx_crc = {crc_dly[1], crc_dly[0]};
    if (byte_cnt < 4) begin
      st = crcfc_pkg::ST_SHORT;
    end else if (ovf_seen) begin
      st = crcfc_pkg::ST_OVERFLOW;
    end else if (lead[0] != start_cfg) begin
      st = crcfc_pkg::ST_BAD_START;
    end else if (rx_crc != crc_acc) begin
      st = crcfc_pkg::ST_CRC_ERR;
    end else if (lead[1] == 8'h00) begin
      st = crcfc_pkg::ST_DEV_ERR;
    end else begin
      st = crcfc_pkg::ST_OK;
    end
    res.status         = st;
    res.frame_length   = (byte_cnt > 511) ? crcfc_pkg::LEN_SAT : 9'(byte_cnt);
    res.command_echo   = lead[1];
    res.failed_command = (st == crcfc_pkg::ST_DEV_ERR) ? lead[2] : 8'h00;
    res.error_code     = (st == crcfc_pkg::ST_DEV_ERR) ? lead[3] : 8'h00;
    clear_frame();
    return 1'b1;
  endfunction

  // Offer one byte, hold it until transferred, and queue its status if any.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit use_typed,
                           input crcfc_pkg::status_item_t want);
    crcfc_pkg::status_item_t res;
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = '{rx_byte: b, frame_end: last};
    do @(posedge clk_i); while (in_stall_o);
    if (predict_status(in_item_i, res)) begin
      pending_status.push_back(use_typed ? want : res);
    end
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind, input int len);
    logic [7:0]  b;
    logic [15:0] crc;
    crc = crcfc_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        case (kind)
          FK_NOISE, FK_SHORT: b = 8'($urandom);
          FK_BAD_START:       b = start_cfg ^ 8'($urandom_range(1, 255));
          default:            b = start_cfg;
        endcase
      end else if (i == 1) begin
        b = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
      end else if (kind != FK_NOISE && i == len - 2) begin
        b = crc[7:0];
        if (kind == FK_BAD_CRC) begin
          b = b ^ 8'($urandom_range(1, 255));
        end
      end else if (kind != FK_NOISE && i == len - 1) begin
        b = crc[15:8];
      end else begin
        b = 8'($urandom);
      end
      if (i < len - 2) begin
        crc = crc16_byte(crc, b);
      end
      send_byte(b, i == len - 1, 1'b0, NO_WANT);
    end
  endtask

  // Let every status come back, then let the pipeline settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_status.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_start_byte(input logic [7:0] v);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_cfg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off when armed.
  always @(negedge clk_i) begin
    if (hold_arm) begin
      hold_left = HOLD_CYCLES;
      hold_arm  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $error("status transfer with nothing expected: status %0d", out_item_o.status);
        mismatches++;
      end else begin
        got_want = pending_status.pop_front();
        if (out_item_o.status !== got_want.status) begin
          $error("status: expected %0d, got %0d", got_want.status, out_item_o.status);
          mismatches++;
        end
        if (out_item_o.frame_length !== got_want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", got_want.frame_length,
                 out_item_o.frame_length);
          mismatches++;
        end
        if (out_item_o.command_echo !== got_want.command_echo) begin
          $error("command_echo: expected %h, got %h", got_want.command_echo,
                 out_item_o.command_echo);
          mismatches++;
        end
        if (out_item_o.failed_command !== got_want.failed_command) begin
          $error("failed_command: expected %h, got %h", got_want.failed_command,
                 out_item_o.failed_command);
          mismatches++;
        end
        if (out_item_o.error_code !== got_want.error_code) begin
          $error("error_code: expected %h, got %h", got_want.error_code,
                 out_item_o.error_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("crc16_response_frame_checker test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  b;
    frame_kind_e kind;
    int          len;
    int unsigned sent;
    int unsigned pick;
    int unsigned long_left;
    clear_frame();
    start_cfg = crcfc_pkg::START_BYTE_RST;
    tx_crc    = crcfc_pkg::CRC_INIT;
    long_left = 3;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_COUNT; r++) begin
      case (DIR_ROWS[r].src)
        SRC_CRC_LO: b = tx_crc[7:0];
        SRC_CRC_HI: b = tx_crc[15:8];
        default:    b = DIR_ROWS[r].value;
      endcase
      if (DIR_ROWS[r].src == SRC_DATA) begin
        tx_crc = crc16_byte(tx_crc, b);
      end
      if (DIR_ROWS[r].last) begin
        tx_crc = crcfc_pkg::CRC_INIT;
      end
      send_byte(b, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    // largest frame that fits, then one byte past the bound
    send_frame(FK_GOOD, FRAME_MAX);
    send_frame(FK_GOOD, FRAME_MAX + 1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_start_byte(8'h00);
        1:       set_start_byte(8'hFF);
        2:       set_start_byte(8'($urandom));
        default: set_start_byte(crcfc_pkg::START_BYTE_RST);
      endcase
      quiet = (phase == 2);
      if (phase == 1) begin
        hold_arm = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 2 && long_left > 0) begin
          kind = FK_LONG;
          long_left--;
        end else if (pick < 60) begin
          kind = FK_GOOD;
        end else if (pick < 70) begin
          kind = FK_BAD_CRC;
        end else if (pick < 78) begin
          kind = FK_BAD_START;
        end else if (pick < 86) begin
          kind = FK_SHORT;
        end else begin
          kind = FK_NOISE;
        end
        case (kind)
          FK_SHORT: len = $urandom_range(1, 3);
          FK_LONG:  len = $urandom_range(FRAME_MAX - 2, FRAME_MAX + 12);
          FK_NOISE: len = $urandom_range(1, 12);
          default:  len = $urandom_range(4, 12);
        endcase
        send_frame(kind, len);
        sent += len;
      end
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("crc16_response_frame_checker test passed");
    end else begin
      $display("crc16_response_frame_checker test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/crcfc_pkg.sv
design/crcfc_crc_byte.sv
design/crcfc_frame.sv
design/crc16_response_frame_checker.sv
verif/crc16_response_frame_checker_tb.sv
